// File: hw/rtl/rgb_to_hsl_top_macros.svh
// Assertion macros shared by the RGB to HSL converter RTL.
`ifndef RGB_TO_HSL_TOP_MACROS_SVH
`define RGB_TO_HSL_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle; uses clk and rst_n of the including scope.
`define RGBHSL_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never hold while out of reset.
`define RGBHSL_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: hw/rtl/rgbhsl_pkg.sv
// Types, constants and helpers of the RGB to HSL converter.
`default_nettype none

package rgbhsl_pkg;

    localparam int HUE_W   = 15;
    localparam int SAT_W   = 13;
    localparam int LIGHT_W = 9;
    localparam int ALPHA_W = 8;

    // Quotient bits of both dividers (hue fraction <= 7680, saturation <= 4096)
    localparam int QUO_W = 13;

    localparam int TURN_UNITS = 23040;

    // 7680 = 2^13 - 2^9, numerator scale of the hue fraction
    localparam int HUE_HI_SHIFT = 13;
    localparam int HUE_LO_SHIFT = 9;
    // 2 * 4096, saturation numerator scale
    localparam int SAT_SHIFT = 13;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;

    typedef enum logic [1:0] {
        SEC_RED_LO = 2'd0,   // red max, green >= blue
        SEC_RED_HI = 2'd1,   // red max, green < blue
        SEC_GREEN  = 2'd2,
        SEC_BLUE   = 2'd3
    } sector_t;

    typedef struct packed {
        logic                gray;
        sector_t             sector;
        logic [LIGHT_W-1:0]  lightness;
        logic [ALPHA_W-1:0]  alpha;
    } side_t;

    // Hue offset added to the fraction quotient q = round(3840*(diff+d)/d),
    // that is 3840*(k-1) modulo 2^16.
    function automatic logic [15:0] hue_base(input sector_t sec);
        logic [15:0] base;
        case (sec)
            SEC_RED_LO: base = 16'hF100;     // -3840
            SEC_RED_HI: base = 16'd19200;
            SEC_GREEN:  base = 16'd3840;
            SEC_BLUE:   base = 16'd11520;
            default:    base = 16'd0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rgbhsl_fifo.sv
// Small register FIFO used between front and back and at the result side.
`default_nettype none

module rgbhsl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      cnt_reg;
    logic [AW:0]      cnt_next;
    logic             wr_en;
    logic             rd_en;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rgbhsl_front.sv
// Front end: max/min, sector, lightness and divider operands of one pixel.
`default_nettype none

module rgbhsl_front #(
    parameter int CHAN_W = 8
) (
    input  wire logic [CHAN_W-1:0]               red,
    input  wire logic [CHAN_W-1:0]               green,
    input  wire logic [CHAN_W-1:0]               blue,
    input  wire logic [rgbhsl_pkg::ALPHA_W-1:0]  alpha,
    output rgbhsl_pkg::side_t                    side,
    output logic      [CHAN_W-1:0]               d,
    output logic      [CHAN_W-1:0]               den,
    output logic      [CHAN_W:0]                 dd
);
    import rgbhsl_pkg::*;

    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W:0]   sum;
    logic [CHAN_W:0]   den_wide;
    logic              red_max;
    logic              green_max;
    sector_t           sector;

    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);

        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;

        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};

        // above half scale the denominator is 2*FULL - sum
        if (sum > {1'b0, {CHAN_W{1'b1}}})
            den_wide = {{CHAN_W{1'b1}}, 1'b0} - sum;
        else
            den_wide = sum;
        den = den_wide[CHAN_W-1:0];

        // dd = diff + d, always in 0..2d; wraps cleanly modulo 2^(CHAN_W+1)
        if (red_max)
        begin
            sector = (green < blue) ? SEC_RED_HI : SEC_RED_LO;
            dd     = {1'b0, green} - {1'b0, blue} + {1'b0, d};
        end
        else if (green_max)
        begin
            sector = SEC_GREEN;
            dd     = {1'b0, blue} - {1'b0, red} + {1'b0, d};
        end
        else
        begin
            sector = SEC_BLUE;
            dd     = {1'b0, red} - {1'b0, green} + {1'b0, d};
        end

        side.gray      = (d == '0);
        side.sector    = sector;
        side.lightness = LIGHT_W'(sum);
        side.alpha     = alpha;
    end

endmodule

`default_nettype wire

// File: hw/rtl/rgbhsl_div.sv
// Pipelined restoring divider, one quotient bit per stage, fixed quotient width.
`default_nettype none

module rgbhsl_div #(
    parameter int DIV_W = 9
) (
    input  wire logic                                  clk,
    input  wire logic [DIV_W+rgbhsl_pkg::QUO_W-1:0]    num,
    input  wire logic [DIV_W-1:0]                      den,
    output logic      [rgbhsl_pkg::QUO_W-1:0]          quo
);
    import rgbhsl_pkg::*;

    // The caller guarantees num < den * 2^QUO_W, so the top part starts below den.
    logic [DIV_W-1:0] rem_reg  [QUO_W];
    logic [DIV_W-1:0] rem_next [QUO_W];
    logic [QUO_W-1:0] low_reg  [QUO_W];
    logic [QUO_W-1:0] low_next [QUO_W];
    logic [DIV_W-1:0] den_reg  [QUO_W];
    logic [DIV_W-1:0] rem_in   [QUO_W];
    logic [QUO_W-1:0] low_in   [QUO_W];
    logic [DIV_W-1:0] den_in   [QUO_W];

    always_comb
    begin
        rem_in[0] = num[DIV_W+QUO_W-1:QUO_W];
        low_in[0] = num[QUO_W-1:0];
        den_in[0] = den;
        for (int s = 1; s < QUO_W; s++)
        begin
            rem_in[s] = rem_reg[s-1];
            low_in[s] = low_reg[s-1];
            den_in[s] = den_reg[s-1];
        end
    end

    always_comb
    begin
        logic [DIV_W:0] trial;
        logic           ge;
        for (int s = 0; s < QUO_W; s++)
        begin
            trial       = {rem_in[s], low_in[s][QUO_W-1]};
            ge          = (trial >= {1'b0, den_in[s]});
            rem_next[s] = ge ? DIV_W'(trial - {1'b0, den_in[s]}) : DIV_W'(trial);
            low_next[s] = {low_in[s][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            rem_reg[s] <= rem_next[s];
            low_reg[s] <= low_next[s];
            den_reg[s] <= den_in[s];
        end
    end

    assign quo = low_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: hw/rtl/rgbhsl_back.sv
// Back end: credit-gated issue, hue and saturation dividers, final hue offset and wrap.
`default_nettype none

`include "rgb_to_hsl_top_macros.svh"

module rgbhsl_back #(
    parameter int CHAN_W = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               mid_empty,
    output logic                                    mid_pop,
    input  wire rgbhsl_pkg::side_t                  side_in,
    input  wire logic [CHAN_W-1:0]                  d_in,
    input  wire logic [CHAN_W-1:0]                  den_in,
    input  wire logic [CHAN_W:0]                    dd_in,
    output logic                                    out_push,
    input  wire logic                               out_taken,
    output logic      [rgbhsl_pkg::HUE_W-1:0]       hue_res,
    output logic      [rgbhsl_pkg::SAT_W-1:0]       sat_res,
    output logic      [rgbhsl_pkg::LIGHT_W-1:0]     light_res,
    output logic      [rgbhsl_pkg::ALPHA_W-1:0]     alpha_res
);
    import rgbhsl_pkg::*;

    localparam int DIV_W    = CHAN_W + 1;
    localparam int NUM_W    = DIV_W + QUO_W;
    localparam int PIPE_LAT = QUO_W + 1;
    localparam int CNT_W    = $clog2(OUT_DEPTH) + 1;

    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;
    logic             valid_reg [PIPE_LAT];
    side_t            side_reg  [PIPE_LAT];
    logic [NUM_W-1:0] hnum_reg;
    logic [DIV_W-1:0] hden_reg;
    logic [NUM_W-1:0] snum_reg;
    logic [DIV_W-1:0] sden_reg;
    logic [NUM_W-1:0] hnum_next;
    logic [NUM_W-1:0] snum_next;
    logic [NUM_W-1:0] dd_ext;
    logic [QUO_W-1:0] hue_q;
    logic [QUO_W-1:0] sat_q;
    logic [15:0]      hue_sum;
    side_t            side_last;

    // issue only when a slot in the result queue is reserved for the request
    assign mid_pop   = !mid_empty && (used_reg != CNT_W'(OUT_DEPTH));
    assign used_next = used_reg + CNT_W'(mid_pop) - CNT_W'(out_taken);

    always_comb
    begin
        dd_ext    = NUM_W'(dd_in);
        // hue: 7680*(diff+d) + d over 2d ; sat: 8192*d + den over 2*den
        hnum_next = (dd_ext << HUE_HI_SHIFT) - (dd_ext << HUE_LO_SHIFT) + NUM_W'(d_in);
        snum_next = (NUM_W'(d_in) << SAT_SHIFT) + NUM_W'(den_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int s = 0; s < PIPE_LAT; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            used_reg     <= used_next;
            valid_reg[0] <= mid_pop;
            for (int s = 1; s < PIPE_LAT; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hnum_reg    <= hnum_next;
        hden_reg    <= {d_in, 1'b0};
        snum_reg    <= snum_next;
        sden_reg    <= {den_in, 1'b0};
        side_reg[0] <= side_in;
        for (int s = 1; s < PIPE_LAT; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    rgbhsl_div #(.DIV_W(DIV_W)) u_hue_div (
        .clk (clk),
        .num (hnum_reg),
        .den (hden_reg),
        .quo (hue_q)
    );

    rgbhsl_div #(.DIV_W(DIV_W)) u_sat_div (
        .clk (clk),
        .num (snum_reg),
        .den (sden_reg),
        .quo (sat_q)
    );

    always_comb
    begin
        side_last = side_reg[PIPE_LAT-1];
        hue_sum   = 16'(hue_q) + hue_base(side_last.sector);
        // gray pixels and a full turn both give hue zero
        if (side_last.gray || (hue_sum >= 16'(TURN_UNITS)))
            hue_res = '0;
        else
            hue_res = HUE_W'(hue_sum);
        sat_res   = side_last.gray ? '0 : SAT_W'(sat_q);
        light_res = side_last.lightness;
        alpha_res = side_last.alpha;
        out_push  = valid_reg[PIPE_LAT-1];
    end

    `RGBHSL_ASSERT_NEVER(a_credit_bound, used_reg > CNT_W'(OUT_DEPTH), "credit count overflow")
    `RGBHSL_ASSERT_IMPLY(a_fixed_latency, out_push, $past(mid_pop, PIPE_LAT), "early result")
    `RGBHSL_ASSERT_IMPLY(a_no_lost_issue, $past(mid_pop, PIPE_LAT), out_push, "lost result")
    `RGBHSL_ASSERT_IMPLY(a_push_has_credit, out_push, used_reg != '0, "no reserved slot")

endmodule

`default_nettype wire

// File: hw/rtl/rgb_to_hsl_top.sv
// Top level of the RGB to HSL pixel converter.
//
//  channel  | handshake        | fields
//  ---------+------------------+-----------------------------------------
//  pixel in | push / full      | red, green, blue, alpha
//  HSL out  | pop / empty      | hue, saturation, lightness, alpha_out
//
// One request per clock sustained while pop keeps up; a request accepted passes
// the mid queue, the operand register, 13 divider stages and the result queue
// write before it shows up on the result ports.
// The latency is set by the two 13-stage restoring dividers (hue and saturation).
// rst_n clears queue pointers, credits and stage valids at once; no warm-up pass.
// When pop stalls, credits for the 16-entry result queue run out, the back stops
// issuing, the 4-entry mid queue fills and full rises.
`default_nettype none

`include "rgb_to_hsl_top_macros.svh"

module rgb_to_hsl_top #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [CHANNEL_BITS-1:0]            red,
    input  wire logic [CHANNEL_BITS-1:0]            green,
    input  wire logic [CHANNEL_BITS-1:0]            blue,
    input  wire logic [rgbhsl_pkg::ALPHA_W-1:0]     alpha,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic      [rgbhsl_pkg::HUE_W-1:0]       hue,
    output logic      [rgbhsl_pkg::SAT_W-1:0]       saturation,
    output logic      [rgbhsl_pkg::LIGHT_W-1:0]     lightness,
    output logic      [rgbhsl_pkg::ALPHA_W-1:0]     alpha_out
);
    import rgbhsl_pkg::*;

    localparam int MID_W = $bits(side_t) + 3 * CHANNEL_BITS + 1;
    localparam int OUT_W = HUE_W + SAT_W + LIGHT_W + ALPHA_W;

    // front -> mid queue
    side_t                   f_side;
    logic [CHANNEL_BITS-1:0] f_d;
    logic [CHANNEL_BITS-1:0] f_den;
    logic [CHANNEL_BITS:0]   f_dd;

    // mid queue -> back
    logic [MID_W-1:0]        mid_rdata;
    logic                    mid_empty;
    logic                    mid_pop;
    side_t                   m_side;
    logic [CHANNEL_BITS-1:0] m_d;
    logic [CHANNEL_BITS-1:0] m_den;
    logic [CHANNEL_BITS:0]   m_dd;

    // back -> result queue
    logic                    out_push;
    logic                    out_full;
    logic                    out_taken;
    logic [HUE_W-1:0]        b_hue;
    logic [SAT_W-1:0]        b_sat;
    logic [LIGHT_W-1:0]      b_light;
    logic [ALPHA_W-1:0]      b_alpha;
    logic [OUT_W-1:0]        out_rdata;

    // Front: classify the pixel combinationally and park it in the mid queue.
    rgbhsl_front #(.CHAN_W(CHANNEL_BITS)) u_front (
        .red   (red),
        .green (green),
        .blue  (blue),
        .alpha (alpha),
        .side  (f_side),
        .d     (f_d),
        .den   (f_den),
        .dd    (f_dd)
    );

    rgbhsl_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({f_side, f_d, f_den, f_dd}),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .full  (full),
        .empty (mid_empty)
    );

    assign {m_side, m_d, m_den, m_dd} = mid_rdata;

    // Back: divider pipeline; it issues only against free result-queue slots,
    // so it never has to stall mid-flight.
    rgbhsl_back #(.CHAN_W(CHANNEL_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .side_in   (m_side),
        .d_in      (m_d),
        .den_in    (m_den),
        .dd_in     (m_dd),
        .out_push  (out_push),
        .out_taken (out_taken),
        .hue_res   (b_hue),
        .sat_res   (b_sat),
        .light_res (b_light),
        .alpha_res (b_alpha)
    );

    assign out_taken = pop && !empty;

    rgbhsl_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata ({b_hue, b_sat, b_light, b_alpha}),
        .pop   (pop),
        .rdata (out_rdata),
        .full  (out_full),
        .empty (empty)
    );

    assign {hue, saturation, lightness, alpha_out} = out_rdata;

    `RGBHSL_ASSERT_IMPLY(a_no_result_drop, out_push, !out_full, "result queue overflow")
    `RGBHSL_ASSERT_IMPLY(a_hue_range, !empty, hue < HUE_W'(TURN_UNITS), "hue out of range")
    `RGBHSL_ASSERT_IMPLY(a_sat_range, !empty, saturation <= SAT_W'(4096), "saturation above one")

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the RGB to HSL pixel converter.
`timescale 1ns / 1ps

module tb;

    import rgbhsl_pkg::*;

    // Fixed-point constants of the conversion at 8-bit channels
    localparam int  CHAN_BITS    = 8;
    localparam int  CHAN_FULL    = 255;
    localparam int  HUE_SECTOR   = 3840;    // 60 degrees in 1/64 degree
    localparam int  HUE_TURN     = 23040;   // 360 degrees in 1/64 degree
    localparam int  SAT_ONE      = 4096;    // 1.0 in Q12

    localparam int  PIXEL_TOTAL  = 1750;
    localparam int  RAND_CHUNKS  = 5;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  REPORT_MAX   = 10;

    // Gap styles for the request and result sides
    localparam int  GAPS_NONE    = 0;
    localparam int  GAPS_MIXED   = 1;
    localparam int  GAPS_LONG    = 2;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   sat;
        logic [LIGHT_W-1:0] light;
        logic [ALPHA_W-1:0] alpha;
    } hsl_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] r;
        logic [CHAN_BITS-1:0] g;
        logic [CHAN_BITS-1:0] b;
        logic [ALPHA_W-1:0]   a;
        logic                 typed_in;   // expected result given in the table
        hsl_t                 hsl;
    } pixel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 pop = 1'b0;
    logic [CHAN_BITS-1:0] red = '0;
    logic [CHAN_BITS-1:0] green = '0;
    logic [CHAN_BITS-1:0] blue = '0;
    logic [ALPHA_W-1:0]   alpha = '0;
    logic                 full;
    logic                 empty;
    logic [HUE_W-1:0]     hue;
    logic [SAT_W-1:0]     saturation;
    logic [LIGHT_W-1:0]   lightness;
    logic [ALPHA_W-1:0]   alpha_out;

    hsl_t   pending_hsl[$];     // expected results, oldest first
    pixel_t directed_px[$];
    hsl_t   got_hsl;
    hsl_t   want_hsl;

    int     source_style = GAPS_MIXED;
    int     sink_style = GAPS_MIXED;
    int     sink_hold = 0;
    int     pixels_sent = 0;
    int     results_seen = 0;
    int     mismatches = 0;
    int     gray_sent = 0;
    int     cycles = 0;

    rgb_to_hsl_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .empty      (empty),
        .pop        (pop),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .alpha_out  (alpha_out)
    );

    always #2 clk = ~clk;

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_hsl.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Expected HSL for one pixel. Lightness is max+min; gray pixels get zero
    // hue and saturation; hue comes from the sector of the largest channel,
    // red winning ties over green, green over blue.
    function automatic hsl_t convert_pixel(input logic [CHAN_BITS-1:0] r,
                                           input logic [CHAN_BITS-1:0] g,
                                           input logic [CHAN_BITS-1:0] b,
                                           input logic [ALPHA_W-1:0] a);
        longint rv, gv, bv, mx, mn, d, sum, k, diff, den, hue_q, sat_q;
        hsl_t   res;
        rv = longint'(r);
        gv = longint'(g);
        bv = longint'(b);
        mx = rv;
        mn = rv;
        if (gv > mx) mx = gv;
        if (bv > mx) mx = bv;
        if (gv < mn) mn = gv;
        if (bv < mn) mn = bv;
        d = mx - mn;
        sum = mx + mn;
        hue_q = 0;
        sat_q = 0;
        if (d != 0)
        begin
            // bright half divides by the distance to white instead
            den = (sum > CHAN_FULL) ? 2 * CHAN_FULL - sum : sum;
            sat_q = (2 * d * SAT_ONE + den) / (2 * den);
            if (mx == rv)
            begin
                k = (gv < bv) ? 6 : 0;
                diff = gv - bv;
            end
            else if (mx == gv)
            begin
                k = 2;
                diff = bv - rv;
            end
            else
            begin
                k = 4;
                diff = rv - gv;
            end
            // round to nearest, ties up; a full turn wraps to zero
            hue_q = (2 * HUE_SECTOR * (k * d + diff) + d) / (2 * d);
            if (hue_q >= HUE_TURN) hue_q = 0;
        end
        res.hue = hue_q[HUE_W-1:0];
        res.sat = sat_q[SAT_W-1:0];
        res.light = sum[LIGHT_W-1:0];
        res.alpha = a;
        return res;
    endfunction

    // Idle length: NONE gives zero; MIXED mostly zero, some short, a few long; LONG more and longer gaps.
    function automatic int gap_len(input int style);
        int pick;
        pick = $urandom_range(0, 99);
        if (style == GAPS_NONE) return 0;
        if (style == GAPS_LONG)
        begin
            if (pick < 40) return 0;
            if (pick < 70) return $urandom_range(1, 4);
            return $urandom_range(10, 60);
        end
        if (pick < 65) return 0;
        if (pick < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_row(input int r, input int g, input int b, input int a,
                           input logic typed_in, input int h, input int s,
                           input int l);
        pixel_t px;
        px.r = r[CHAN_BITS-1:0];
        px.g = g[CHAN_BITS-1:0];
        px.b = b[CHAN_BITS-1:0];
        px.a = a[ALPHA_W-1:0];
        px.typed_in = typed_in;
        px.hsl.hue = h[HUE_W-1:0];
        px.hsl.sat = s[SAT_W-1:0];
        px.hsl.light = l[LIGHT_W-1:0];
        px.hsl.alpha = a[ALPHA_W-1:0];
        directed_px.push_back(px);
    endtask

    // Random pixel: plain noise plus grays, near grays, ties and edge-heavy colors,
    // since those steer the sector choice and the saturation branch.
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     kind, base;
        kind = $urandom_range(0, 99);
        px.r = CHAN_BITS'($urandom_range(0, CHAN_FULL));
        px.g = CHAN_BITS'($urandom_range(0, CHAN_FULL));
        px.b = CHAN_BITS'($urandom_range(0, CHAN_FULL));
        px.a = ALPHA_W'($urandom_range(0, 255));
        px.typed_in = 1'b0;
        px.hsl = '0;
        if (kind < 55)
        begin
        end
        else if (kind < 65)
        begin
            px.g = px.r;
            px.b = px.r;
        end
        else if (kind < 75)
        begin
            case ($urandom_range(0, 2))
                0: px.g = px.r;
                1: px.b = px.g;
                default: px.b = px.r;
            endcase
        end
        else if (kind < 85)
        begin
            case ($urandom_range(0, 2))
                0: px.r = CHAN_BITS'($urandom_range(0, 1) ? CHAN_FULL : 0);
                1: px.g = CHAN_BITS'($urandom_range(0, 1) ? CHAN_FULL : 0);
                default: px.b = CHAN_BITS'($urandom_range(0, 1) ? CHAN_FULL : 0);
            endcase
        end
        else
        begin
            // near gray: tiny spread stresses the dividers
            base = $urandom_range(2, CHAN_FULL - 2);
            px.r = CHAN_BITS'(base + $urandom_range(0, 4) - 2);
            px.g = CHAN_BITS'(base + $urandom_range(0, 4) - 2);
            px.b = CHAN_BITS'(base + $urandom_range(0, 4) - 2);
        end
        return px;
    endfunction

    // Drive one request, hold it until full reads low after an edge, then log its expected result.
    task automatic send_pixel(input pixel_t px);
        int n;
        n = gap_len(source_style);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
        push <= 1'b1;
        red <= px.r;
        green <= px.g;
        blue <= px.b;
        alpha <= px.a;
        @(posedge clk);
        while (full) @(posedge clk);
        if (px.typed_in)
            pending_hsl.push_back(px.hsl);
        else
            pending_hsl.push_back(convert_pixel(px.r, px.g, px.b, px.a));
        pixels_sent++;
        if (px.r == px.g && px.g == px.b) gray_sent++;
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_hsl.size() != 0) @(posedge clk);
    endtask

    // Result side: check each popped result, then pick the next pop level.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                got_hsl.hue = hue;
                got_hsl.sat = saturation;
                got_hsl.light = lightness;
                got_hsl.alpha = alpha_out;
                if (pending_hsl.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: stray result h=%0d s=%0d l=%0d a=%0d",
                                 $realtime, hue, saturation, lightness, alpha_out);
                end
                else
                begin
                    want_hsl = pending_hsl.pop_front();
                    if (got_hsl.hue !== want_hsl.hue || got_hsl.sat !== want_hsl.sat ||
                        got_hsl.light !== want_hsl.light ||
                        got_hsl.alpha !== want_hsl.alpha)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch exp h=%0d s=%0d l=%0d a=%0d",
                                     $realtime, want_hsl.hue, want_hsl.sat,
                                     want_hsl.light, want_hsl.alpha);
                            $display("    got h=%0d s=%0d l=%0d a=%0d",
                                     got_hsl.hue, got_hsl.sat, got_hsl.light,
                                     got_hsl.alpha);
                        end
                    end
                end
            end
            if (sink_hold > 0)
            begin
                pop <= 1'b0;
                sink_hold = sink_hold - 1;
            end
            else
            begin
                sink_hold = gap_len(sink_style);
                if (sink_hold == 0)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    sink_hold = sink_hold - 1;
                end
            end
        end
    end

    initial
    begin
        int chunk, left;
        int per_chunk;

        // Directed rows: primaries, grays and two-channel ties are typed in, the rest predicted.
        add_row(  0,   0,   0, 8'h00, 1'b1,     0,    0,   0);  // black
        add_row(255, 255, 255, 8'hFF, 1'b1,     0,    0, 510);  // white
        add_row(255,   0,   0, 8'hAA, 1'b1,     0, 4096, 255);  // pure red
        add_row(  0, 255,   0, 8'h55, 1'b1,  7680, 4096, 255);  // pure green
        add_row(  0,   0, 255, 8'h0F, 1'b1, 15360, 4096, 255);  // pure blue
        add_row(128, 128, 128, 8'hF0, 1'b1,     0,    0, 256);  // mid gray
        add_row(  1,   1,   1, 8'h01, 1'b1,     0,    0,   2);  // near black gray
        add_row(255, 255,   0, 8'h80, 1'b1,  3840, 4096, 255);  // red/green tie
        add_row(  0, 255, 255, 8'h7F, 1'b1, 11520, 4096, 255);  // green/blue tie
        add_row(255,   0, 255, 8'hFE, 1'b1, 19200, 4096, 255);  // red/blue tie
        add_row(255,   0,   1, 8'h33, 1'b0, 0, 0, 0);  // red sector, green below blue
        add_row(254,   0, 255, 8'hCC, 1'b0, 0, 0, 0);  // blue just above red
        add_row(255, 200, 100, 8'h12, 1'b0, 0, 0, 0);  // bright half
        add_row(200,  55,  55, 8'h34, 1'b0, 0, 0, 0);  // sum right at full scale
        add_row(201,  55,  55, 8'h56, 1'b0, 0, 0, 0);  // sum one above full scale
        add_row(  1,   0,   0, 8'h78, 1'b0, 0, 0, 0);  // smallest spread, dark
        add_row(254, 255, 255, 8'h9A, 1'b0, 0, 0, 0);  // smallest spread, bright
        add_row(128, 127, 127, 8'hBC, 1'b0, 0, 0, 0);  // smallest spread, mid
        add_row(100, 200,  50, 8'hDE, 1'b0, 0, 0, 0);  // green sector
        add_row( 60,  30, 200, 8'h21, 1'b0, 0, 0, 0);  // blue sector
        add_row( 30,  20,  10, 8'h43, 1'b0, 0, 0, 0);  // red sector, dark
        add_row( 10,  20, 250, 8'h65, 1'b0, 0, 0, 0);  // blue sector, red < green

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_px[i])
            send_pixel(directed_px[i]);
        drain_results();

        // Random chunks; the idling mix is chosen per chunk, with a full drain between
        // chunks. The third chunk starves pop so the queues fill and full rises.
        left = PIXEL_TOTAL - directed_px.size();
        per_chunk = left / RAND_CHUNKS;
        for (chunk = 0; chunk < RAND_CHUNKS; chunk++)
        begin
            case (chunk)
                0:
                begin
                    source_style = GAPS_NONE;
                    sink_style = GAPS_NONE;
                end
                1:
                begin
                    source_style = GAPS_MIXED;
                    sink_style = GAPS_MIXED;
                end
                2:
                begin
                    source_style = GAPS_NONE;
                    sink_style = GAPS_LONG;
                end
                3:
                begin
                    source_style = GAPS_LONG;
                    sink_style = GAPS_NONE;
                end
                default:
                begin
                    source_style = GAPS_MIXED;
                    sink_style = GAPS_MIXED;
                end
            endcase
            if (chunk == RAND_CHUNKS - 1) per_chunk = left;
            repeat (per_chunk) send_pixel(random_pixel());
            left = left - per_chunk;
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels (%0d directed, %0d gray), checked %0d results",
                 pixels_sent, directed_px.size(), gray_sent, results_seen);
        $display("Idling mixes: back-to-back, mixed gaps, pop starved, sparse requests");
        if (mismatches == 0 && pending_hsl.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rgbhsl_pkg.sv
hw/rtl/rgbhsl_fifo.sv
hw/rtl/rgbhsl_front.sv
hw/rtl/rgbhsl_div.sv
hw/rtl/rgbhsl_back.sv
hw/rtl/rgb_to_hsl_top.sv
test/tb.sv
